@@ rtl/core/tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants and types for the trial candidate selector.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned IDENT_W = 16;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CFG_IW  = 2;

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    // Command codes of an input word
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_ABORT  = 2'd2;

    // Trial phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WARM = 2'd1;
    localparam logic [1:0] PH_MEAS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_WARMUP  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MEASURE = 2'd1;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted input word
        logic prep;        // register counter differences
        logic div_start;   // launch the average-ticks division
        logic score_mode;  // evaluate the advance with the quotient
        logic commit;      // update state and load the result word
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_status;

endpackage

@@ rtl/core/trial_candidate_selector_top.sv @@
// ----------------------------------------------------------------------------
// trial_candidate_selector_top: sequences load-balance trials, keeps the best
// One word at a time: capture, register differences, evaluate, then commit once the
// result slot is free; a closed window with blocks counted runs the 32-step divider.
// Reset (i_rst_n low, synchronous): idle phase, no result pending, 500/1000 ms.
// ----------------------------------------------------------------------------
module trial_candidate_selector_top #(
    parameter int MAX_CANDIDATES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input word channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [tcs_pkg::DATA_W-1:0]    i_now_time,
    input  logic [tcs_pkg::CNT_W-1:0]     i_candidate_total,
    input  logic                          i_patch_loaded,
    input  logic [tcs_pkg::IDENT_W-1:0]   i_patch_ident,
    input  logic                          i_patch_loading,
    input  logic                          i_audio_playing,
    input  logic                          i_overload_stopped,
    input  logic [tcs_pkg::DATA_W-1:0]    i_tick_total,
    input  logic [tcs_pkg::DATA_W-1:0]    i_block_total,
    input  logic [tcs_pkg::DATA_W-1:0]    i_overrun_total,
    input  logic                          i_auto_request,
    // result word channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_apply_valid,
    output logic [tcs_pkg::IDX_W-1:0]     o_apply_index,
    output logic                          o_save_to_patch,
    output logic                          o_silence_audio,
    output logic [1:0]                    o_trial_phase,
    output logic                          o_auto_running,
    output logic                          o_clear_overload_flag,
    output logic                          o_notify_optimizing,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcs_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [tcs_pkg::TIME_W-1:0]    i_cfg_data
);
    import tcs_pkg::*;

    t_dp_cmd    cmd_bus;
    t_dp_status status;

    // Configuration writes land at once; the user must send them while idle; not enforced
    assign o_cfg_ready = 1'b1;

    // The sequencer holds off new words until the current one is resolved;
    // the result register lets a finished word wait while the next is taken.
    tcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd_bus   (cmd_bus),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Trial state, scoring, divider and result register
    tcs_dp #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd_bus             (cmd_bus),
        .o_status              (status),
        .i_cfg_we              (i_cfg_valid && o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_cmd                 (i_cmd),
        .i_now_time            (i_now_time),
        .i_candidate_total     (i_candidate_total),
        .i_patch_loaded        (i_patch_loaded),
        .i_patch_ident         (i_patch_ident),
        .i_patch_loading       (i_patch_loading),
        .i_audio_playing       (i_audio_playing),
        .i_overload_stopped    (i_overload_stopped),
        .i_tick_total          (i_tick_total),
        .i_block_total         (i_block_total),
        .i_overrun_total       (i_overrun_total),
        .i_auto_request        (i_auto_request),
        .o_apply_valid         (o_apply_valid),
        .o_apply_index         (o_apply_index),
        .o_save_to_patch       (o_save_to_patch),
        .o_silence_audio       (o_silence_audio),
        .o_trial_phase         (o_trial_phase),
        .o_auto_running        (o_auto_running),
        .o_clear_overload_flag (o_clear_overload_flag),
        .o_notify_optimizing   (o_notify_optimizing)
    );

`ifndef ASSERT_OFF
    // An accepted word holds off the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after accept");

    // Idle phase means no silencing and no automatic run
    a_idle_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_trial_phase == PH_IDLE) |-> (!o_silence_audio && !o_auto_running))
        else $error("flags left set in idle phase");

    // Saving only happens when a run finishes
    a_save_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_save_to_patch) |-> (o_trial_phase == PH_IDLE))
        else $error("save while a trial is running");

    // No index without an apply
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_apply_valid) |-> (o_apply_index == '0))
        else $error("apply index set without apply");
`endif

endmodule

@@ rtl/core/tcs_div.sv @@
// ----------------------------------------------------------------------------
// tcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tcs_pkg::DATA_W-1:0]   i_dividend,
    input  logic [tcs_pkg::DATA_W-1:0]   i_divisor,
    output logic [tcs_pkg::DATA_W-1:0]   o_quotient,
    output logic                         o_done
);
    import tcs_pkg::*;

    localparam int unsigned STEP_W = $clog2(DATA_W);

    logic [DATA_W-1:0] r_rem, r_quo, r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy, r_done;
    logic [DATA_W:0]   shifted, trial;

    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!trial[DATA_W]) begin
                r_rem <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

@@ rtl/core/tcs_dp.sv @@
// ----------------------------------------------------------------------------
// tcs_dp
// Trial state, scoring logic, configuration registers and result word.
// ----------------------------------------------------------------------------
module tcs_dp #(
    parameter int MAX_CANDIDATES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcs_pkg::t_dp_cmd              i_cmd_bus,
    output tcs_pkg::t_dp_status           o_status,
    // configuration write
    input  logic                          i_cfg_we,
    input  logic [tcs_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [tcs_pkg::TIME_W-1:0]    i_cfg_data,
    // input word fields
    input  logic [1:0]                    i_cmd,
    input  logic [tcs_pkg::DATA_W-1:0]    i_now_time,
    input  logic [tcs_pkg::CNT_W-1:0]     i_candidate_total,
    input  logic                          i_patch_loaded,
    input  logic [tcs_pkg::IDENT_W-1:0]   i_patch_ident,
    input  logic                          i_patch_loading,
    input  logic                          i_audio_playing,
    input  logic                          i_overload_stopped,
    input  logic [tcs_pkg::DATA_W-1:0]    i_tick_total,
    input  logic [tcs_pkg::DATA_W-1:0]    i_block_total,
    input  logic [tcs_pkg::DATA_W-1:0]    i_overrun_total,
    input  logic                          i_auto_request,
    // result word
    output logic                          o_apply_valid,
    output logic [tcs_pkg::IDX_W-1:0]     o_apply_index,
    output logic                          o_save_to_patch,
    output logic                          o_silence_audio,
    output logic [1:0]                    o_trial_phase,
    output logic                          o_auto_running,
    output logic                          o_clear_overload_flag,
    output logic                          o_notify_optimizing
);
    import tcs_pkg::*;

    // captured input word
    logic [1:0]         r_cmd;
    logic [DATA_W-1:0]  r_now, r_ticks, r_blocks, r_ovrs;
    logic [CNT_W-1:0]   r_ctot;
    logic               r_ploaded, r_ploading, r_playing, r_ovl, r_auto_req;
    logic [IDENT_W-1:0] r_pident;

    // differences
    logic [DATA_W-1:0]  r_elapsed, r_tdiff, r_bdiff, r_odiff;

    // trial state
    logic [1:0]         r_phase, n_phase;
    logic [CNT_W-1:0]   r_cur, n_cur, r_count, n_count;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic [DATA_W-1:0]  r_best_avg, n_best_avg, r_best_ovr, n_best_ovr;
    logic [DATA_W-1:0]  r_win, n_win, r_tstart, n_tstart;
    logic [DATA_W-1:0]  r_bstart, n_bstart, r_ostart, n_ostart;
    logic [IDENT_W-1:0] r_patch, n_patch;
    logic               r_silent, n_silent, r_auto, n_auto;
    logic [TIME_W-1:0]  r_warm, r_meas;

    // result flags for this step
    logic               res_apply, res_save, res_clear, res_notify;
    logic [IDX_W-1:0]   res_index;

    logic               need_div, do_adv, better, start_ok;
    logic [CNT_W-1:0]   n_cap, nxt;
    logic [DATA_W-1:0]  adv_avg, adv_ovr, quotient;
    logic               div_done;

    tcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd_bus.div_start),
        .i_dividend (r_tdiff),
        .i_divisor  (r_bdiff),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    // Capture the word and its counter differences
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.capture) begin
            r_cmd      <= i_cmd;
            r_now      <= i_now_time;
            r_ctot     <= i_candidate_total;
            r_ploaded  <= i_patch_loaded;
            r_pident   <= i_patch_ident;
            r_ploading <= i_patch_loading;
            r_playing  <= i_audio_playing;
            r_ovl      <= i_overload_stopped;
            r_ticks    <= i_tick_total;
            r_blocks   <= i_block_total;
            r_ovrs     <= i_overrun_total;
            r_auto_req <= i_auto_request;
        end
        if (i_cmd_bus.prep) begin
            r_elapsed <= r_now - r_win;
            r_tdiff   <= r_ticks - r_tstart;
            r_bdiff   <= r_blocks - r_bstart;
            r_odiff   <= r_ovrs - r_ostart;
        end
    end

    assign n_cap    = (int'(r_ctot) > MAX_CANDIDATES) ? CNT_W'(MAX_CANDIDATES) : r_ctot;
    assign start_ok = (r_phase == PH_IDLE) && r_ploaded && (n_cap != '0);

    assign adv_avg = i_cmd_bus.score_mode ? quotient : ALL_ONES;
    assign adv_ovr = i_cmd_bus.score_mode ? r_odiff  : ALL_ONES;
    assign better  = (adv_ovr < r_best_ovr) ||
                     ((adv_ovr == r_best_ovr) && (adv_avg < r_best_avg));
    assign nxt     = r_cur + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_cur      = r_cur;
        n_count    = r_count;
        n_best_idx = r_best_idx;
        n_best_avg = r_best_avg;
        n_best_ovr = r_best_ovr;
        n_win      = r_win;
        n_tstart   = r_tstart;
        n_bstart   = r_bstart;
        n_ostart   = r_ostart;
        n_patch    = r_patch;
        n_silent   = r_silent;
        n_auto     = r_auto;
        res_apply  = 1'b0;
        res_index  = '0;
        res_save   = 1'b0;
        res_clear  = 1'b0;
        res_notify = 1'b0;
        need_div   = 1'b0;
        do_adv     = 1'b0;

        if (i_cmd_bus.score_mode) begin
            do_adv = 1'b1;
        end else begin
            case (r_cmd)
                CMD_START, CMD_UPDATE: begin
                    if (r_cmd == CMD_UPDATE && r_phase != PH_IDLE) begin
                        if (!r_ploaded || r_ploading || r_pident != r_patch) begin
                            n_silent = 1'b0;
                            n_auto   = 1'b0;
                            n_phase  = PH_IDLE;
                        end else if (!r_playing) begin
                            if (r_ovl) begin
                                res_clear = 1'b1;
                                do_adv    = 1'b1;
                            end else begin
                                n_silent = 1'b0;
                                n_auto   = 1'b0;
                                n_phase  = PH_IDLE;
                                res_save = 1'b1;
                            end
                        end else if (r_phase == PH_WARM) begin
                            if (r_elapsed >= DATA_W'(r_warm)) begin
                                n_tstart = r_ticks;
                                n_bstart = r_blocks;
                                n_ostart = r_ovrs;
                                n_win    = r_now;
                                n_phase  = PH_MEAS;
                            end
                        end else if (r_phase == PH_MEAS) begin
                            if (r_elapsed >= DATA_W'(r_meas)) begin
                                if (r_bdiff == '0) begin
                                    n_win = r_now;
                                end else begin
                                    need_div = 1'b1;
                                end
                            end
                        end
                    end else if (r_cmd == CMD_START || r_auto_req) begin
                        res_notify = (r_cmd == CMD_UPDATE);
                        if (start_ok) begin
                            n_count    = n_cap;
                            n_patch    = r_pident;
                            n_cur      = '0;
                            n_best_idx = '0;
                            n_best_avg = ALL_ONES;
                            n_best_ovr = ALL_ONES;
                            res_apply  = 1'b1;
                            res_clear  = 1'b1;
                            if (n_cap == CNT_W'(1)) begin
                                res_save = 1'b1;
                                n_silent = 1'b0;
                                n_auto   = 1'b0;
                                n_phase  = PH_IDLE;
                            end else begin
                                n_silent = 1'b1;
                                n_win    = r_now;
                                n_phase  = PH_WARM;
                                if (r_cmd == CMD_UPDATE) begin
                                    n_auto = 1'b1;
                                end
                            end
                        end else if (r_cmd == CMD_UPDATE) begin
                            n_auto = 1'b0;
                        end
                    end
                end
                CMD_ABORT: begin
                    if (r_phase != PH_IDLE) begin
                        n_silent = 1'b0;
                        n_auto   = 1'b0;
                        n_phase  = PH_IDLE;
                        res_save = 1'b1;
                        if (r_ploaded) begin
                            res_apply = 1'b1;
                            res_index = (r_best_ovr == ALL_ONES) ? '0 : r_best_idx;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Move on to the next candidate, or finish and apply the winner
        if (do_adv) begin
            if (better) begin
                n_best_ovr = adv_ovr;
                n_best_avg = adv_avg;
                n_best_idx = r_cur[IDX_W-1:0];
            end
            n_cur     = nxt;
            res_apply = 1'b1;
            if (nxt < r_count) begin
                res_index = nxt[IDX_W-1:0];
                n_win     = r_now;
                n_phase   = PH_WARM;
            end else begin
                res_index = better ? r_cur[IDX_W-1:0] : r_best_idx;
                res_save  = 1'b1;
                n_silent  = 1'b0;
                n_auto    = 1'b0;
                n_phase   = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cur      <= '0;
            r_count    <= '0;
            r_best_idx <= '0;
            r_best_avg <= ALL_ONES;
            r_best_ovr <= ALL_ONES;
            r_win      <= '0;
            r_tstart   <= '0;
            r_bstart   <= '0;
            r_ostart   <= '0;
            r_patch    <= '0;
            r_silent   <= 1'b0;
            r_auto     <= 1'b0;
            r_warm     <= TIME_W'(500);
            r_meas     <= TIME_W'(1000);
        end else begin
            if (i_cmd_bus.commit) begin
                r_phase    <= n_phase;
                r_cur      <= n_cur;
                r_count    <= n_count;
                r_best_idx <= n_best_idx;
                r_best_avg <= n_best_avg;
                r_best_ovr <= n_best_ovr;
                r_win      <= n_win;
                r_tstart   <= n_tstart;
                r_bstart   <= n_bstart;
                r_ostart   <= n_ostart;
                r_patch    <= n_patch;
                r_silent   <= n_silent;
                r_auto     <= n_auto;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WARMUP:  r_warm <= i_cfg_data;
                    CFG_MEASURE: r_meas <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.commit) begin
            o_apply_valid         <= res_apply;
            o_apply_index         <= res_apply ? res_index : '0;
            o_save_to_patch       <= res_save;
            o_silence_audio       <= n_silent;
            o_trial_phase         <= n_phase;
            o_auto_running        <= n_auto;
            o_clear_overload_flag <= res_clear;
            o_notify_optimizing   <= res_notify;
        end
    end

    assign o_status.need_div = need_div;
    assign o_status.div_done = div_done;

endmodule

@@ rtl/core/tcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer: accept a word, evaluate it, divide if scoring, emit the result.
// ----------------------------------------------------------------------------
module tcs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_stall,
    input  tcs_pkg::t_dp_status  i_status,
    output tcs_pkg::t_dp_cmd     o_cmd_bus,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);
    import tcs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SCORE = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free, accept;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign accept    = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state   = r_state;
        o_cmd_bus = '0;
        o_cmd_bus.capture = accept;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd_bus.prep = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                if (i_status.need_div) begin
                    o_cmd_bus.div_start = 1'b1;
                    n_state             = S_DIV;
                end else if (slot_free) begin
                    o_cmd_bus.commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_SCORE;
                end
            end
            S_SCORE: begin
                o_cmd_bus.score_mode = 1'b1;
                if (slot_free) begin
                    o_cmd_bus.commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd_bus.commit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
